// File: hdl/fcm_pkg.sv
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared constants, opcodes and controller/datapath handshake types for the
// FAT chain manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcm_pkg;

    localparam int DATA_W            = 16;
    localparam int OP_W              = 3;
    localparam int IDX_W             = 13;
    localparam int POS_W             = 13;
    localparam int CFG_W             = 14;
    localparam int CMP_W             = 17;
    localparam int TABLE_ENTRIES_DEF = 8192;

    localparam logic [DATA_W-1:0] END_MARK   = 16'hFFFF;
    localparam logic [CFG_W-1:0]  USED_RESET = 14'd8192;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_READ   = 3'd1,
        OP_LOCATE = 3'd2,
        OP_APPEND = 3'd3,
        OP_FREE   = 3'd4,
        OP_COUNT  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_CUR  = 2'd1,
        RD_SCAN = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_LOAD  = 2'd0,
        WR_TAIL  = 2'd1,
        WR_MARK  = 2'd2,
        WR_CLEAR = 2'd3
    } wr_sel_t;

    typedef struct packed {
        logic    load_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cur_from_mem;
        logic    res_mem;
        logic    res_cur;
        logic    res_zero;
        logic    res_inc;
        logic    res_fresh;
        logic    set_bad;
        logic    pos_inc;
        logic    steps_inc;
        logic    scan_init;
        logic    scan_step;
        logic    out_load;
    } fcm_cmd_t;

    typedef struct packed {
        op_t  op;
        logic idx_ok;
        logic head_end;
        logic cur_end;
        logic cur_ok;
        logic step_done;
        logic nx_term;
        logic steps_ge_lim;
        logic scan_more;
        logic rd_vld;
        logic rd_zero;
        logic out_free;
    } fcm_sts_t;

endpackage

// File: hdl/fcm_ifs.sv
// ----------------------------------------------------------------------------
// fcm_ifs
// Request and response channels of the FAT chain manager, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fcm_req_if
    import fcm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  entry_index;
    logic [DATA_W-1:0] entry_value;
    logic [DATA_W-1:0] chain_head;
    logic [POS_W-1:0]  block_position;

    modport source (
        output valid, opcode, entry_index, entry_value, chain_head, block_position,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, entry_value, chain_head, block_position,
        output ready
    );
endinterface

interface fcm_rsp_if
    import fcm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              status;

    modport source (
        output valid, result_value, status,
        input  ready
    );
    modport sink (
        input  valid, result_value, status,
        output ready
    );
endinterface

// File: hdl/fat_chain_manager.sv
// ----------------------------------------------------------------------------
// fat_chain_manager
// FAT16-style link table: load, read, locate, append, free chain, count free.
// Load and opcodes 6/7 finish in decode; read waits on a single table read;
// locate walks and free clears the chain link by link; count scans the table.
// Append: tail walk, a one-read-per-cycle free scan, tail link, end mark.
// One item in flight; the single-port table read bounds every walk and scan.
// Reset: async active low; the table is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat_chain_manager
    import fcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    fcm_req_if.sink          req,
    fcm_rsp_if.source        rsp
);

    fcm_cmd_t cmd;
    fcm_sts_t sts;
    logic     in_ready;

    assign req.ready = in_ready;

    fcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fcm_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .opcode         (req.opcode),
        .entry_index    (req.entry_index),
        .entry_value    (req.entry_value),
        .chain_head     (req.chain_head),
        .block_position (req.block_position),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_value      (rsp.result_value),
        .out_status     (rsp.status)
    );

endmodule

// File: hdl/fcm_ctrl.sv
// ----------------------------------------------------------------------------
// fcm_ctrl
// Sequencer: decodes the opcode and steps the datapath through table reads,
// writes, chain walks and scans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcm_ctrl
    import fcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  fcm_sts_t sts,
    output fcm_cmd_t cmd
);

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0_0000_0000_0001,
        S_DECODE     = 13'b0_0000_0000_0010,
        S_READ_WAIT  = 13'b0_0000_0000_0100,
        S_LOC_CHECK  = 13'b0_0000_0000_1000,
        S_LOC_WAIT   = 13'b0_0000_0001_0000,
        S_TAIL_CHECK = 13'b0_0000_0010_0000,
        S_TAIL_WAIT  = 13'b0_0000_0100_0000,
        S_SCAN       = 13'b0_0000_1000_0000,
        S_LINK       = 13'b0_0001_0000_0000,
        S_MARK       = 13'b0_0010_0000_0000,
        S_FREE_CHECK = 13'b0_0100_0000_0000,
        S_FREE_WAIT  = 13'b0_1000_0000_0000,
        S_DONE       = 13'b1_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_LOAD:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_LOAD;
                        end
                        state_next = S_DONE;
                    end
                    OP_READ:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_IDX;
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    OP_LOCATE:
                    begin
                        state_next = sts.head_end ? S_DONE : S_LOC_CHECK;
                    end
                    OP_APPEND:
                    begin
                        if (sts.head_end)
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_TAIL_CHECK;
                        end
                    end
                    OP_FREE:
                    begin
                        state_next = S_FREE_CHECK;
                    end
                    OP_COUNT:
                    begin
                        cmd.res_zero  = 1'b1;
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                cmd.res_mem = 1'b1;
                state_next  = S_DONE;
            end
            S_LOC_CHECK:
            begin
                if (sts.step_done)
                begin
                    cmd.res_cur = 1'b1;
                    state_next  = S_DONE;
                end
                else if (sts.cur_end)
                begin
                    state_next = S_DONE;
                end
                else if (!sts.cur_ok)
                begin
                    cmd.set_bad = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_LOC_WAIT;
                end
            end
            S_LOC_WAIT:
            begin
                cmd.cur_from_mem = 1'b1;
                cmd.pos_inc      = 1'b1;
                state_next       = S_LOC_CHECK;
            end
            S_TAIL_CHECK:
            begin
                if (!sts.cur_ok)
                begin
                    cmd.set_bad = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_TAIL_WAIT;
                end
            end
            S_TAIL_WAIT:
            begin
                if (sts.nx_term)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else if (sts.steps_ge_lim)
                begin
                    // chain loops back on itself
                    cmd.set_bad = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.steps_inc    = 1'b1;
                    cmd.cur_from_mem = 1'b1;
                    state_next       = S_TAIL_CHECK;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_more)
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RD_SCAN;
                    cmd.scan_step = 1'b1;
                end
                if (sts.rd_vld && sts.rd_zero)
                begin
                    if (sts.op == OP_APPEND)
                    begin
                        cmd.res_fresh = 1'b1;
                        state_next    = S_LINK;
                    end
                    else
                    begin
                        cmd.res_inc = 1'b1;
                    end
                end
                else if (!sts.scan_more && !sts.rd_vld)
                begin
                    if (sts.op == OP_APPEND)
                    begin
                        cmd.set_bad = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_LINK:
            begin
                if (!sts.head_end)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_TAIL;
                end
                state_next = S_MARK;
            end
            S_MARK:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_MARK;
                state_next = S_DONE;
            end
            S_FREE_CHECK:
            begin
                if (sts.cur_end)
                begin
                    state_next = S_DONE;
                end
                else if (!sts.cur_ok)
                begin
                    cmd.set_bad = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_FREE_WAIT;
                end
            end
            S_FREE_WAIT:
            begin
                cmd.wr_en        = 1'b1;
                cmd.wr_sel       = WR_CLEAR;
                cmd.cur_from_mem = 1'b1;
                state_next       = S_FREE_CHECK;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/fcm_dp.sv
// ----------------------------------------------------------------------------
// fcm_dp
// Datapath: link table memory, chain cursor, step counters, scan pointer,
// result and output registers, used-entries register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcm_dp
    import fcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [OP_W-1:0]   opcode,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [DATA_W-1:0] entry_value,
    input  logic [DATA_W-1:0] chain_head,
    input  logic [POS_W-1:0]  block_position,
    input  fcm_cmd_t          cmd,
    output fcm_sts_t          sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_value,
    output logic              out_status
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int LW = $clog2(TABLE_ENTRIES + 1);

    logic [DATA_W-1:0] mem [TABLE_ENTRIES];
    logic [DATA_W-1:0] mem_q;

    logic [CFG_W-1:0]  used_reg;
    logic [OP_W-1:0]   opcode_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] head_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [LW-1:0]     lim_reg;
    logic [LW-1:0]     lim_next;
    logic [DATA_W-1:0] cur_reg;
    logic [DATA_W-1:0] cur_next;
    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] res_next;
    logic              st_reg;
    logic [POS_W-1:0]  pos_cnt_reg;
    logic [LW-1:0]     steps_reg;
    logic [LW-1:0]     scan_reg;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_status_reg;

    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    always_comb
    begin
        if (CMP_W'(used_reg) > CMP_W'(TABLE_ENTRIES))
        begin
            lim_next = LW'(TABLE_ENTRIES);
        end
        else
        begin
            lim_next = LW'(used_reg);
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:  rd_addr = AW'(idx_reg);
            RD_CUR:  rd_addr = AW'(cur_reg);
            RD_SCAN: rd_addr = AW'(scan_reg);
            default: rd_addr = AW'(cur_reg);
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_LOAD:
            begin
                wr_addr = AW'(idx_reg);
                wr_data = val_reg;
            end
            WR_TAIL:
            begin
                wr_addr = AW'(cur_reg);
                wr_data = res_reg;
            end
            WR_MARK:
            begin
                wr_addr = AW'(res_reg);
                wr_data = END_MARK;
            end
            WR_CLEAR:
            begin
                wr_addr = AW'(cur_reg);
                wr_data = '0;
            end
            default:
            begin
                wr_addr = AW'(cur_reg);
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.load_in)
        begin
            cur_next = chain_head;
        end
        else if (cmd.cur_from_mem)
        begin
            cur_next = mem_q;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.load_in)
        begin
            res_next = END_MARK;
        end
        else if (cmd.res_mem)
        begin
            res_next = mem_q;
        end
        else if (cmd.res_cur)
        begin
            res_next = cur_reg;
        end
        else if (cmd.res_zero)
        begin
            res_next = '0;
        end
        else if (cmd.res_inc)
        begin
            res_next = res_reg + 1'b1;
        end
        else if (cmd.res_fresh)
        begin
            res_next = DATA_W'(rd_idx_reg);
        end
    end

    // captured item and walk state
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            opcode_reg <= opcode;
            idx_reg    <= entry_index;
            val_reg    <= entry_value;
            head_reg   <= chain_head;
            pos_reg    <= block_position;
            lim_reg    <= lim_next;
        end
        cur_reg    <= cur_next;
        res_reg    <= res_next;
        rd_idx_reg <= AW'(scan_reg);
        if (cmd.load_in)
        begin
            st_reg <= 1'b0;
        end
        else if (cmd.set_bad)
        begin
            st_reg <= 1'b1;
        end
        if (cmd.load_in)
        begin
            pos_cnt_reg <= '0;
        end
        else if (cmd.pos_inc)
        begin
            pos_cnt_reg <= pos_cnt_reg + 1'b1;
        end
        if (cmd.load_in)
        begin
            steps_reg <= '0;
        end
        else if (cmd.steps_inc)
        begin
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.scan_init)
        begin
            scan_reg <= LW'(1);
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_reg;
            out_status_reg <= st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= USED_RESET;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                used_reg <= cfg_wdata;
            end
            rd_vld_reg <= cmd.scan_step;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.op           = op_t'(opcode_reg);
    assign sts.idx_ok       = (CMP_W'(idx_reg) < CMP_W'(TABLE_ENTRIES));
    assign sts.head_end     = (head_reg == END_MARK);
    assign sts.cur_end      = (cur_reg == END_MARK);
    assign sts.cur_ok       = (cur_reg != '0) && (CMP_W'(cur_reg) < CMP_W'(lim_reg));
    assign sts.step_done    = (pos_cnt_reg == pos_reg);
    assign sts.nx_term      = (mem_q == END_MARK) || (mem_q == '0);
    assign sts.steps_ge_lim = (steps_reg >= lim_reg);
    assign sts.scan_more    = (scan_reg < lim_reg);
    assign sts.rd_vld       = rd_vld_reg;
    assign sts.rd_zero      = (mem_q == '0);
    assign sts.out_free     = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

// File: hdl/fcm_checker.sv
// ----------------------------------------------------------------------------
// fcm_checker
// Port-level checks of the FAT chain manager, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcm_checker
    import fcm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [DATA_W-1:0] rsp_value,
    input logic              rsp_status
);

    // result beat held while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
        else $error("response beat changed while stalled");

    // one item at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in flight");

    // a fresh result beat only follows work that blocked the request side
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !$past(rsp_valid) |-> !$past(req_ready))
        else $error("result beat without preceding work");

    // a failing status always carries the none marker
    a_bad_is_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> rsp_value == END_MARK)
        else $error("bad status with a real result value");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result beat right after reset");

endmodule

bind fat_chain_manager fcm_checker u_fcm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_value  (rsp.result_value),
    .rsp_status (rsp.status)
);
